### sv/bdmd_pkg.sv
// Shared types and constants for the bit-packed depth map decoder.
package bdmd_pkg;

   // One request: a payload byte with its framing flags.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       chunk_start;
      logic       last_byte;
   } req_type;

   // One result: a cell value, or a run of cells that share a value.
   typedef struct packed {
      logic [15:0] depth_value;
      logic [19:0] cell_index;
      logic [20:0] repeat_count;
      logic        truncated;
      logic        done_res;
   } rsp_type;

   // Head of the request queue as seen by the decoder.
   typedef struct packed {
      logic    valid;
      req_type item;
   } head_type;

   // Field being gathered from the bit stream.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ROWS,
      PH_COLS,
      PH_WIDTH,
      PH_BASE,
      PH_DELTA,
      PH_DONE
   } phase_type;

   // Steps of the zero fill that closes a chunk cut short.
   typedef enum logic [1:0] {
      FILL_NONE,
      FILL_PREP,
      FILL_CLAMP,
      FILL_EMIT
   } fill_type;

   // Queue between the request side and the decoder.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // Field widths of the packed format.
   localparam logic [4:0] FIELD_BITS  = 5'd16;
   localparam logic [4:0] NIBBLE_BITS = 5'd4;

endpackage

### sv/bdmd_queue.sv
// Front end: request queue that decouples byte intake from decoding.
module bdmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_stall,
   input  bdmd_pkg::req_type  push_data,
   output bdmd_pkg::head_type head,
   input  logic               head_pop
);
   import bdmd_pkg::*;

   req_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                push;
   logic                pop;

   // Full depends on registered state only.
   assign push_stall = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign push       = push_valid && !push_stall;
   assign pop        = head_pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/bdmd_core.sv
// Back end: bit-field decoder, zero fill sequencer and result register.
module bdmd_core #(
   parameter int MAP_SIDE = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  bdmd_pkg::head_type head,
   output logic               head_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bdmd_pkg::rsp_type  rsp_data
);
   import bdmd_pkg::*;

   localparam int CAP_I = MAP_SIDE * MAP_SIDE;
   localparam int NW    = $clog2(CAP_I + 1);
   localparam int LW    = (NW > 16) ? NW : 16;
   localparam logic [LW-1:0] CAP = LW'(CAP_I);

   // Decoder state.
   phase_type       phase_ff, phase_in;
   fill_type        fill_ff, fill_in;
   logic [15:0]     acc_ff, acc_in;
   logic [4:0]      gath_ff, gath_in;
   logic [15:0]     rows_ff, rows_in;
   logic [15:0]     cols_ff, cols_in;
   logic [15:0]     row_cnt_ff, row_cnt_in;
   logic [15:0]     col_cnt_ff, col_cnt_in;
   logic [3:0]      width_ff, width_in;
   logic [15:0]     base_ff, base_in;
   logic [NW-1:0]   cell_ff, cell_in;
   logic [2:0]      pos_ff, pos_in;
   logic            begun_ff, begun_in;

   // Zero fill working registers.
   logic            part_ff, part_in;
   logic            run_ff, run_in;
   logic            zero_ff, zero_in;
   logic [15:0]     part_val_ff, part_val_in;
   logic [15:0]     run_val_ff, run_val_in;
   logic [15:0]     run_len_ff, run_len_in;
   logic [LW-1:0]   room_ff, room_in;
   logic [31:0]     prod_ff, prod_in;
   logic [LW-1:0]   zlen_ff, zlen_in;

   // Result register.
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_data_ff, out_data_in;

   // Datapath helpers.
   logic            out_free;
   logic            emit;
   rsp_type         res;
   logic [4:0]      fbits;
   logic [4:0]      need;
   logic [3:0]      bleft;
   logic [3:0]      k;
   logic [7:0]      kmask;
   logic [7:0]      chunk;
   logic [15:0]     acc_new;
   logic            complete;
   logic [3:0]      pos_sum;
   logic [LW-1:0]   left;
   logic [LW-1:0]   cell_p1;
   logic [LW-1:0]   ncol;
   logic [LW-1:0]   cell_plus_n;
   logic            last_row;
   logic [16:0]     col_next;
   logic            col_end;
   logic            part;
   logic [LW-1:0]   left1;
   logic [LW-1:0]   rcols;
   logic [LW-1:0]   nrun;
   logic [15:0]     ma;
   logic [15:0]     mb;
   logic [LW-1:0]   left2;
   logic            run_done;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Bit extraction from the current byte.
   always_comb begin
      case (phase_ff)
         PH_WIDTH: fbits = NIBBLE_BITS;
         PH_DELTA: fbits = {1'b0, width_ff};
         default:  fbits = FIELD_BITS;
      endcase
   end

   assign need     = fbits - gath_ff;
   assign bleft    = 4'd8 - {1'b0, pos_ff};
   assign k        = (need < {1'b0, bleft}) ? need[3:0] : bleft;
   assign kmask    = 8'hFF >> (4'd8 - k);
   assign chunk    = (head.item.data_byte >> pos_ff) & kmask;
   assign acc_new  = acc_ff | ({8'd0, chunk} << gath_ff);
   assign complete = ({1'b0, k} == need);
   assign pos_sum  = {1'b0, pos_ff} + k;

   // Map bookkeeping.
   assign left        = CAP - LW'(cell_ff);
   assign cell_p1     = LW'(cell_ff) + LW'(1);
   assign ncol        = (LW'(cols_ff) < left) ? LW'(cols_ff) : left;
   assign cell_plus_n = LW'(cell_ff) + ncol;
   assign last_row    = ((row_cnt_ff + 16'd1) == rows_ff);
   assign col_next    = {1'b0, col_cnt_ff} + 17'd1;
   assign col_end     = (col_next >= {1'b0, cols_ff});
   assign run_done    = (cell_plus_n >= CAP) || last_row;

   // Zero fill preparation: the partial cell, the rest of the row, the later rows.
   assign part  = (phase_ff == PH_DELTA) && (gath_ff != '0) && (LW'(cell_ff) != CAP);
   assign left1 = left - LW'(part);
   assign nrun  = (rcols < left1) ? rcols : left1;
   assign left2 = room_ff - LW'(run_len_ff);

   always_comb begin
      rcols = '0;
      ma    = '0;
      mb    = '0;
      case (phase_ff)
         PH_COLS: begin
            ma = rows_ff;
            mb = acc_ff;
         end
         PH_WIDTH: begin
            ma = rows_ff - row_cnt_ff;
            mb = cols_ff;
         end
         PH_BASE: begin
            rcols = LW'(cols_ff);
            ma    = rows_ff - row_cnt_ff - 16'd1;
            mb    = cols_ff;
         end
         PH_DELTA: begin
            rcols = LW'(cols_ff - col_cnt_ff) - LW'(part);
            ma    = rows_ff - row_cnt_ff - 16'd1;
            mb    = cols_ff;
         end
         default: begin
            rcols = '0;
         end
      endcase
   end

   // Next state and result for the decoder and the fill sequencer.
   always_comb begin
      phase_in    = phase_ff;
      fill_in     = fill_ff;
      acc_in      = acc_ff;
      gath_in     = gath_ff;
      rows_in     = rows_ff;
      cols_in     = cols_ff;
      row_cnt_in  = row_cnt_ff;
      col_cnt_in  = col_cnt_ff;
      width_in    = width_ff;
      base_in     = base_ff;
      cell_in     = cell_ff;
      pos_in      = pos_ff;
      begun_in    = begun_ff;
      part_in     = part_ff;
      run_in      = run_ff;
      zero_in     = zero_ff;
      part_val_in = part_val_ff;
      run_val_in  = run_val_ff;
      run_len_in  = run_len_ff;
      room_in     = room_ff;
      prod_in     = prod_ff;
      zlen_in     = zlen_ff;
      head_pop    = 1'b0;
      emit        = 1'b0;
      res         = '0;
      res.cell_index = 20'(cell_ff);

      if (fill_ff == FILL_PREP) begin
         // Size the partial cell and the row remainder; start the product.
         part_in     = part;
         run_len_in  = nrun[15:0];
         run_in      = (nrun != '0);
         part_val_in = base_ff + acc_ff;
         run_val_in  = (phase_ff == PH_BASE) ? acc_ff : base_ff;
         room_in     = left1;
         prod_in     = 32'(ma) * 32'(mb);
         fill_in     = FILL_CLAMP;
      end else if (fill_ff == FILL_CLAMP) begin
         // Cut the run of zeros at map capacity.
         zlen_in = (64'(prod_ff) > 64'(left2)) ? left2 : LW'(prod_ff);
         zero_in = (zlen_in != '0);
         fill_in = FILL_EMIT;
      end else if (fill_ff == FILL_EMIT) begin
         if (out_free) begin
            emit          = 1'b1;
            res.truncated = 1'b1;
            if (part_ff) begin
               res.depth_value  = part_val_ff;
               res.repeat_count = 21'd1;
               res.done_res     = !(run_ff || zero_ff);
               cell_in          = NW'(cell_p1);
               part_in          = 1'b0;
            end else if (run_ff) begin
               res.depth_value  = run_val_ff;
               res.repeat_count = 21'(run_len_ff);
               res.done_res     = !zero_ff;
               cell_in          = NW'(LW'(cell_ff) + LW'(run_len_ff));
               run_in           = 1'b0;
            end else if (zero_ff) begin
               res.repeat_count = 21'(zlen_ff);
               res.done_res     = 1'b1;
               cell_in          = NW'(LW'(cell_ff) + zlen_ff);
               zero_in          = 1'b0;
            end else begin
               // Nothing was filled: send the completion marker.
               res.done_res = 1'b1;
            end
            if (res.done_res) begin
               phase_in = PH_DONE;
               fill_in  = FILL_NONE;
            end
         end
      end else if (head.valid) begin
         if (head.item.chunk_start && !begun_ff) begin
            // A new chunk clears the decoder before its first bit is read.
            phase_in   = PH_ROWS;
            begun_in   = 1'b1;
            acc_in     = '0;
            gath_in    = '0;
            rows_in    = '0;
            cols_in    = '0;
            row_cnt_in = '0;
            col_cnt_in = '0;
            width_in   = '0;
            base_in    = '0;
            cell_in    = '0;
            pos_in     = '0;
         end else if (phase_ff == PH_IDLE || phase_ff == PH_DONE) begin
            // No chunk in progress: the byte is dropped.
            head_pop = 1'b1;
            begun_in = 1'b0;
            pos_in   = '0;
         end else if (out_free) begin
            // Take as many bits as the current field needs or the byte still holds.
            pos_in = pos_sum[2:0];
            if (complete) begin
               acc_in  = '0;
               gath_in = '0;
               case (phase_ff)
                  PH_ROWS: begin
                     rows_in  = acc_new;
                     phase_in = PH_COLS;
                  end
                  PH_COLS: begin
                     cols_in    = acc_new;
                     row_cnt_in = '0;
                     if (rows_ff == '0) begin
                        emit         = 1'b1;
                        res.done_res = 1'b1;
                        phase_in     = PH_DONE;
                     end else begin
                        phase_in = PH_WIDTH;
                     end
                  end
                  PH_WIDTH: begin
                     width_in = acc_new[3:0];
                     phase_in = PH_BASE;
                  end
                  PH_BASE: begin
                     base_in    = acc_new;
                     col_cnt_in = '0;
                     if (width_ff == '0) begin
                        // A flat row becomes a single run.
                        row_cnt_in = row_cnt_ff + 16'd1;
                        cell_in    = NW'(cell_plus_n);
                        if (ncol != '0) begin
                           emit             = 1'b1;
                           res.depth_value  = acc_new;
                           res.repeat_count = 21'(ncol);
                           res.done_res     = run_done;
                        end else if (run_done) begin
                           emit         = 1'b1;
                           res.done_res = 1'b1;
                        end
                        phase_in = run_done ? PH_DONE : PH_WIDTH;
                     end else if (cols_ff == '0) begin
                        row_cnt_in = row_cnt_ff + 16'd1;
                        if (last_row) begin
                           emit         = 1'b1;
                           res.done_res = 1'b1;
                           phase_in     = PH_DONE;
                        end else begin
                           phase_in = PH_WIDTH;
                        end
                     end else begin
                        phase_in = PH_DELTA;
                     end
                  end
                  PH_DELTA: begin
                     emit             = 1'b1;
                     res.depth_value  = base_ff + acc_new;
                     res.repeat_count = 21'd1;
                     cell_in          = NW'(cell_p1);
                     col_cnt_in       = col_next[15:0];
                     if (cell_p1 >= CAP) begin
                        res.done_res = 1'b1;
                        phase_in     = PH_DONE;
                     end else if (col_end) begin
                        row_cnt_in   = row_cnt_ff + 16'd1;
                        res.done_res = last_row;
                        phase_in     = last_row ? PH_DONE : PH_WIDTH;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end else begin
               acc_in  = acc_new;
               gath_in = gath_ff + {1'b0, k};
            end
            // Release the byte once it is used up or the chunk has ended.
            if (pos_sum[3] || phase_in == PH_DONE) begin
               head_pop = 1'b1;
               begun_in = 1'b0;
               pos_in   = '0;
               if (head.item.last_byte && phase_in != PH_DONE) begin
                  fill_in = FILL_PREP;
               end
            end
         end
      end

      out_valid_in = emit ? 1'b1 : (out_valid_ff && rsp_stall);
      out_data_in  = emit ? res : out_data_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         fill_ff      <= FILL_NONE;
         pos_ff       <= '0;
         begun_ff     <= 1'b0;
         part_ff      <= 1'b0;
         run_ff       <= 1'b0;
         zero_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         begun_ff     <= begun_in;
         part_ff      <= part_in;
         run_ff       <= run_in;
         zero_ff      <= zero_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      gath_ff     <= gath_in;
      rows_ff     <= rows_in;
      cols_ff     <= cols_in;
      row_cnt_ff  <= row_cnt_in;
      col_cnt_ff  <= col_cnt_in;
      width_ff    <= width_in;
      base_ff     <= base_in;
      cell_ff     <= cell_in;
      part_val_ff <= part_val_in;
      run_val_ff  <= run_val_in;
      run_len_ff  <= run_len_in;
      room_ff     <= room_in;
      prod_ff     <= prod_in;
      zlen_ff     <= zlen_in;
      out_data_ff <= out_data_in;
   end

endmodule

### sv/bitpacked_depth_map_decoder.sv
// Top level of the bit-packed depth map decoder.
//
// Requests carry one payload byte each, read LSB first. A request with
// chunk_start set clears the decoder and opens a chunk; last_byte marks the
// end of the data, and a chunk still open then is closed by a zero fill whose
// results carry truncated. Each result is one decoded cell or a run of cells,
// and done_res marks the last result of a chunk.
// A request enters a four-entry queue; while the result register is free, the
// decoder takes one field, or the part of a field that the byte holds, per
// cycle, and pops the byte once its bits are used up or the chunk has ended.
// A chunk_start byte first clears the decoder, and a zero fill steps through
// FILL_PREP and FILL_CLAMP before FILL_EMIT sends its results, each of which
// leaves through the result register.
// Reset empties the queue and the result register and leaves the decoder
// idle: bytes without chunk_start are dropped. While the result side stalls,
// the result register holds, the decoder waits, and requests keep entering
// the queue until it is full.
module bitpacked_depth_map_decoder #(
   parameter int MAP_SIDE = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bdmd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bdmd_pkg::rsp_type rsp_data
);
   import bdmd_pkg::*;

   head_type head;
   logic     head_pop;

   // Request queue.
   bdmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_stall (req_stall),
      .push_data  (req_data),
      .head       (head),
      .head_pop   (head_pop)
   );

   // Decoder and result register.
   bdmd_core #(
      .MAP_SIDE (MAP_SIDE)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .head_pop  (head_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
